@@ design/bwv_pkg.sv @@
// shared types, constants and helpers for the weighted byte vote block
// no dependencies
package bwv_pkg;

  localparam int COPY_LIMIT = 8;
  localparam int IDX_W      = $clog2(COPY_LIMIT);
  localparam int CNT_W      = $clog2(COPY_LIMIT + 1);
  localparam int WGT_W      = 8 + $clog2(COPY_LIMIT);

  typedef struct packed {
    logic [7:0] byte_value;
    logic       usable;
    logic [7:0] confidence;
    logic       last_copy;
  } item_t;

  function automatic logic parity_odd(input logic [7:0] v);
    return ^v;
  endfunction

endpackage

@@ design/weighted_byte_vote.sv @@
// top level of the weighted byte vote: input register, tally, result register
// depends on bwv_pkg and bwv_tally
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | byte_value, usable, confidence, last_copy
//  out     | output    | out_valid/out_stall| voted_byte
//
// one beat per cycle is accepted unless in_stall; a result passes both registers
// the tally over up to COPY_LIMIT entries compares combinationally, updates on advance
// rst clears the input and result valids and the tally counts
// in_stall rises only while a last beat waits behind a stalled result
module weighted_byte_vote import bwv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] byte_value,
  input  logic       usable,
  input  logic [7:0] confidence,
  input  logic       last_copy,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] voted_byte
);

  logic       in_full;
  item_t      in_item;
  logic       out_free;
  logic       advance;
  logic       accept;
  logic [7:0] result;

  assign out_free = !out_valid || !out_stall;
  assign advance  = in_full && (!in_item.last_copy || out_free);
  assign in_stall = in_full && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item <= '{byte_value: byte_value, usable: usable,
                   confidence: confidence, last_copy: last_copy};
    end
  end

  bwv_tally u_tally (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_item.last_copy) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_item.last_copy) begin
      voted_byte <= result;
    end
  end

endmodule

@@ design/bwv_tally.sv @@
// per-position tally of weight by distinct byte value, with a running winner
// depends on bwv_pkg
module bwv_tally import bwv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  item_t      item,
  output logic [7:0] result
);

  logic [7:0]       tally_values  [COPY_LIMIT];
  logic [WGT_W-1:0] tally_weights [COPY_LIMIT];
  logic [CNT_W-1:0] value_count;
  logic [CNT_W-1:0] copy_index;

  logic             lead_valid;
  logic [IDX_W-1:0] lead_idx;
  logic [7:0]       lead_value;
  logic             lead_clean;
  logic [WGT_W-1:0] lead_weight;

  logic [WGT_W-1:0] weight;
  logic             take;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] cand_idx;
  logic [WGT_W-1:0] cand_weight;
  logic             cand_clean;
  logic             cand_wins;
  logic             room;
  logic             update;
  logic             lead_valid_next;
  logic [7:0]       lead_value_next;

  always_comb begin
    weight = (item.confidence == 8'd0) ? WGT_W'(1) : WGT_W'(item.confidence);
    take   = item.usable && (copy_index < CNT_W'(COPY_LIMIT));
    hit     = 1'b0;
    hit_idx = '0;
    for (int k = 0; k < COPY_LIMIT; k++) begin
      if ((CNT_W'(k) < value_count) && (tally_values[k] == item.byte_value)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(k);
      end
    end
    cand_idx    = hit ? hit_idx : value_count[IDX_W-1:0];
    cand_weight = hit ? tally_weights[hit_idx] + weight : weight;
    cand_clean  = parity_odd(item.byte_value);
    room        = hit || (value_count < CNT_W'(COPY_LIMIT));
    update      = take && room;
    // the updated entry holds the newest copy, so equal weight is enough
    cand_wins = !lead_valid
             || (hit && (hit_idx == lead_idx))
             || (cand_clean && !lead_clean)
             || ((cand_clean == lead_clean) && (cand_weight >= lead_weight));
    lead_valid_next = lead_valid || update;
    lead_value_next = (update && cand_wins) ? item.byte_value : lead_value;
    if (copy_index == '0) begin
      result = item.byte_value;
    end else if (lead_valid_next) begin
      result = lead_value_next;
    end else begin
      result = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value_count <= '0;
      copy_index  <= '0;
      lead_valid  <= 1'b0;
    end else if (step) begin
      if (item.last_copy) begin
        value_count <= '0;
        copy_index  <= '0;
        lead_valid  <= 1'b0;
      end else begin
        if (copy_index < CNT_W'(COPY_LIMIT)) begin
          copy_index <= copy_index + CNT_W'(1);
        end
        if (update) begin
          lead_valid <= 1'b1;
          if (!hit) begin
            value_count <= value_count + CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && !item.last_copy && update) begin
      tally_values[cand_idx]  <= item.byte_value;
      tally_weights[cand_idx] <= cand_weight;
      if (cand_wins) begin
        lead_idx    <= cand_idx;
        lead_value  <= item.byte_value;
        lead_clean  <= cand_clean;
        lead_weight <= cand_weight;
      end
    end
  end

endmodule

@@ design/bwv_checker.sv @@
// port-level checks for weighted_byte_vote, attached by bind
// depends on weighted_byte_vote's ports only
module bwv_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       last_copy,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] voted_byte
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(voted_byte))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && last_copy, 2))
    else $error("result without a last beat two cycles earlier");

endmodule

bind weighted_byte_vote bwv_checker u_bwv_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .last_copy  (last_copy),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .voted_byte (voted_byte)
);
